// ===== hdl/sudf_pkg.sv =====
// Package for the stepper UART datagram framer: action and result codes,
// datagram constants, the CRC8 byte update and the structs between modules.
// No dependencies.
`default_nettype none

package sudf_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [7:0] SYNC_BYTE = 8'h05;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  // Byte positions within a datagram
  localparam logic [2:0] POS_SYNC  = 3'd0;
  localparam logic [2:0] POS_NODE  = 3'd1;
  localparam logic [2:0] POS_REG   = 3'd2;
  localparam logic [2:0] POS_DATA0 = 3'd3;
  localparam logic [2:0] POS_DATA1 = 3'd4;
  localparam logic [2:0] POS_DATA2 = 3'd5;
  localparam logic [2:0] POS_DATA3 = 3'd6;
  localparam logic [2:0] POS_CRC_W = 3'd7;
  localparam logic [2:0] POS_CRC_R = 3'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  typedef struct packed {
    logic        complete;
    logic [31:0] value;
    logic [6:0]  register_addr;
    logic        crc_error;
  } rx_reply_t;

  // CRC8, poly 0x07, data fed least significant bit first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int j = 0; j < 8; j++) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sudf_in_if.sv =====
// Input channel of the datagram framer: valid/ready plus one request or
// received byte. No dependencies.
`default_nettype none

interface sudf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  reg_address;
  logic [31:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, output action, output reg_address,
                  output write_value, output rx_byte, input ready);
  modport sink (input valid, input action, input reg_address,
                input write_value, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/sudf_out_if.sv =====
// Output channel of the datagram framer: valid/ready plus one transmit byte
// or completed reply. No dependencies.
`default_nettype none

interface sudf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] read_value;
  logic [6:0]  reply_register;
  logic        crc_error;

  modport source (output valid, output kind, output tx_byte, output last,
                  output read_value, output reply_register, output crc_error,
                  input ready);
  modport sink (input valid, input kind, input tx_byte, input last,
                input read_value, input reply_register, input crc_error,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/sudf_tx_framer.sv =====
// Request serializer: walks the datagram byte by byte and keeps a running
// CRC8 over the bytes already sent. Depends on sudf_pkg.
`default_nettype none

module sudf_tx_framer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            is_write,
  input  wire logic [6:0]      reg_address,
  input  wire logic [31:0]     write_value,
  input  wire logic [7:0]      node_address,
  output sudf_pkg::tx_beat_t   beat
);
  import sudf_pkg::*;

  logic [2:0] byte_idx;
  logic [7:0] crc;
  logic [7:0] body_byte;

  always_comb begin
    case (byte_idx)
      POS_SYNC:  body_byte = SYNC_BYTE;
      POS_NODE:  body_byte = node_address;
      POS_REG:   body_byte = {is_write, reg_address};
      POS_DATA0: body_byte = write_value[31:24];
      POS_DATA1: body_byte = write_value[23:16];
      POS_DATA2: body_byte = write_value[15:8];
      POS_DATA3: body_byte = write_value[7:0];
      default:   body_byte = 8'h00;
    endcase
  end

  assign beat.last = is_write ? (byte_idx == POS_CRC_W) : (byte_idx == POS_CRC_R);
  assign beat.data = beat.last ? crc : body_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= POS_SYNC;
      crc      <= 8'h00;
    end else if (advance) begin
      if (beat.last) begin
        byte_idx <= POS_SYNC;
        crc      <= 8'h00;
      end else begin
        byte_idx <= byte_idx + 3'd1;
        crc      <= crc8_feed(crc, body_byte);
      end
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && beat.last) |=> (byte_idx == POS_SYNC && crc == 8'h00))
    else $error("framer did not restart after the CRC byte");

endmodule

`default_nettype wire

// ===== hdl/sudf_rx_deframer.sv =====
// Reply receiver: counts reply bytes, captures register and data bytes and
// runs the CRC8 over the first seven. Depends on sudf_pkg.
`default_nettype none

module sudf_rx_deframer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic            clear,
  input  wire logic [7:0]      rx_byte,
  output sudf_pkg::rx_reply_t  reply
);
  import sudf_pkg::*;

  logic [2:0]  rx_count;
  logic [7:0]  rx_crc;
  logic [31:0] rx_data;
  logic [6:0]  rx_register;

  assign reply.complete      = (rx_count == POS_CRC_W);
  assign reply.value         = rx_data;
  assign reply.register_addr = rx_register;
  assign reply.crc_error     = (rx_byte != rx_crc);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rx_count    <= 3'd0;
      rx_crc      <= 8'h00;
      rx_data     <= 32'h0;
      rx_register <= 7'h0;
    end else if (take) begin
      if (reply.complete) begin
        // data and register are kept; the next reply overwrites them
        rx_count <= 3'd0;
        rx_crc   <= 8'h00;
      end else begin
        rx_count <= rx_count + 3'd1;
        rx_crc   <= crc8_feed(rx_crc, rx_byte);
        if (rx_count == POS_REG) begin
          rx_register <= rx_byte[6:0];
        end else if (rx_count >= POS_DATA0) begin
          rx_data <= {rx_data[23:0], rx_byte};
        end
      end
    end
  end

  a_wrap_after_crc: assert property (@(posedge clk) disable iff (rst)
    (take && !clear && reply.complete) |=> (rx_count == 3'd0 && rx_crc == 8'h00))
    else $error("reply counter did not wrap after the CRC byte");

endmodule

`default_nettype wire

// ===== hdl/stepper_uart_datagram_framer_unit.sv =====
// Stepper UART datagram framer top level: input register, request
// serializer, reply receiver and output register.
// Depends on sudf_pkg, sudf_in_if, sudf_out_if, sudf_tx_framer, sudf_rx_deframer.
//
// Usage:
//   in_ch carries one item per transfer: a write request (action 0), a read
//   request (action 1) or one received reply byte (action 2); action 3 is
//   dropped. out_ch carries transmit bytes (kind 0, last set on the CRC byte)
//   and completed replies (kind 1) after the eighth reply byte.
//   cfg_wr_en/cfg_wr_data set the node address; write it only while idle.
// Timing:
//   An accepted item reaches the input register; its first result goes to the
//   output register once that is free. A write request holds the input
//   register for its 8 datagram bytes and a read request for its 4, one byte
//   per cycle while out_ch.ready stays high, set by the single byte-wide
//   output register. Reply bytes stream at one per cycle; only the eighth
//   waits for a free output register. A read request clears the reply receiver.
// Reset (rst, synchronous): empties both registers, zeroes the node address,
//   the byte counter and the reply receiver.
// Stall: while out_ch.ready is low the output register holds its transfer;
//   reply bytes that give no result and dropped action-3 items still drain;
//   anything else waits and in_ch.ready drops once the input register is full.
`default_nettype none

module stepper_uart_datagram_framer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  sudf_in_if.sink         in_ch,
  sudf_out_if.source      out_ch
);
  import sudf_pkg::*;

  logic [7:0] node_address;

  logic        cur_valid;
  logic [1:0]  cur_action;
  logic [6:0]  cur_reg;
  logic [31:0] cur_value;
  logic [7:0]  cur_rxb;

  logic        o_valid;
  logic        o_kind;
  logic [7:0]  o_tx;
  logic        o_last;
  logic [31:0] o_val;
  logic [6:0]  o_reg;
  logic        o_err;

  tx_beat_t  beat;
  rx_reply_t reply;

  logic is_req;
  logic is_rx;
  logic emits;
  logic out_free;
  logic step;
  logic cur_done;
  logic in_take;

  assign is_req   = (cur_action == ACT_WRITE) || (cur_action == ACT_READ);
  assign is_rx    = (cur_action == ACT_RX);
  assign emits    = is_req || (is_rx && reply.complete);
  assign out_free = !o_valid || out_ch.ready;
  assign step     = cur_valid && (out_free || !emits);
  assign cur_done = is_req ? beat.last : 1'b1;

  assign in_ch.ready = !cur_valid || (step && cur_done);
  assign in_take     = in_ch.valid && in_ch.ready;

  sudf_tx_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .advance      (step && is_req),
    .is_write     (cur_action == ACT_WRITE),
    .reg_address  (cur_reg),
    .write_value  (cur_value),
    .node_address (node_address),
    .beat         (beat)
  );

  sudf_rx_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .take    (step && is_rx),
    .clear   (step && cur_action == ACT_READ),
    .rx_byte (cur_rxb),
    .reply   (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= 8'h00;
    end else if (cfg_wr_en) begin
      node_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (in_take) begin
      cur_valid <= 1'b1;
    end else if (step && cur_done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_action <= in_ch.action;
      cur_reg    <= in_ch.reg_address;
      cur_value  <= in_ch.write_value;
      cur_rxb    <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (step && emits) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emits) begin
      if (is_req) begin
        o_kind <= KIND_TX;
        o_tx   <= beat.data;
        o_last <= beat.last;
        o_val  <= 32'h0;
        o_reg  <= 7'h0;
        o_err  <= 1'b0;
      end else begin
        o_kind <= KIND_REPLY;
        o_tx   <= 8'h00;
        o_last <= 1'b0;
        o_val  <= reply.value;
        o_reg  <= reply.register_addr;
        o_err  <= reply.crc_error;
      end
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.kind           = o_kind;
  assign out_ch.tx_byte        = o_tx;
  assign out_ch.last           = o_last;
  assign out_ch.read_value     = o_val;
  assign out_ch.reply_register = o_reg;
  assign out_ch.crc_error      = o_err;

  a_reply_not_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind == KIND_REPLY) |-> !o_last)
    else $error("completed reply flagged as last byte");

  a_take_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (in_take && cur_valid) |-> (step && cur_done))
    else $error("input register overwritten while busy");

  a_no_overwrite_out: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !out_ch.ready) |-> !(step && emits))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
